// ----- hdl/md4_pkg.sv -----
// Shared constants, types and helper functions for the MD4 digest block.
`default_nettype none

package md4_pkg;

    localparam logic [31:0] INIT_A   = 32'h6745_2301;
    localparam logic [31:0] INIT_B   = 32'hefcd_ab89;
    localparam logic [31:0] INIT_C   = 32'h98ba_dcfe;
    localparam logic [31:0] INIT_D   = 32'h1032_5476;
    localparam logic [31:0] K_ROUND2 = 32'h5a82_7999;
    localparam logic [31:0] K_ROUND3 = 32'h6ed9_eba1;
    localparam logic [31:0] PAD_MARK = 32'h0000_0080;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned STEPS     = 48;
    localparam int unsigned CNT_W     = 6;
    localparam int unsigned BLK_WORDS = 16;
    localparam int unsigned ADDR_W    = 4;

    localparam logic [1:0] ROUND_1 = 2'd0;
    localparam logic [1:0] ROUND_2 = 2'd1;
    localparam logic [1:0] ROUND_3 = 2'd2;

    // Round and position within a group of four for one compression step.
    typedef struct packed {
        logic [1:0] round;
        logic [1:0] pos;
    } step_ctl_t;

    // Message word used by step i of the compression.
    function automatic logic [ADDR_W-1:0] word_order(input logic [CNT_W-1:0] i);
        logic [ADDR_W-1:0] j;
        logic [ADDR_W-1:0] r;
        j = i[3:0];
        case (i[5:4])
            ROUND_2: r = {j[1:0], j[3:2]};
            ROUND_3: r = {j[0], j[1], j[2], j[3]};
            default: r = j;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] rot_amount(input step_ctl_t c);
        logic [4:0] r;
        case ({c.round, c.pos})
            4'b00_00: r = 5'd3;
            4'b00_01: r = 5'd7;
            4'b00_10: r = 5'd11;
            4'b00_11: r = 5'd19;
            4'b01_00: r = 5'd3;
            4'b01_01: r = 5'd5;
            4'b01_10: r = 5'd9;
            4'b01_11: r = 5'd13;
            4'b10_00: r = 5'd3;
            4'b10_01: r = 5'd9;
            4'b10_10: r = 5'd11;
            4'b10_11: r = 5'd15;
            default:  r = 5'd3;
        endcase
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                 input logic [4:0] s);
        logic [2*WORD_W-1:0] w;
        w = {v, v} << s;
        return w[2*WORD_W-1:WORD_W];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/md4_message_digest.sv -----
// Top level of the MD4 digest block: word intake, padding, block buffer and compression.
`default_nettype none

// Channel   | Direction | Contents
// s_ (in)   | slave     | tdata: message_word; tuser: byte_count; tlast: last_word
// m_ (out)  | master    | tdata: digest_word; tuser: word_index; tlast: digest_done
//
// A word that does not complete a 64-byte block is only written into the block buffer.
// A word that completes a block also starts a compression: the compression steps (one
// step per cycle, paced by the registered read of the buffer memory), then a fold of
// the working words into the chaining words.
// The last word adds padding words, one or two compressions and four output transfers.
// Reset loads the MD4 initial values and clears length and fill.
// While m_tready is low the current digest word holds; no input is taken meanwhile.
module md4_message_digest (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] message_word
    input  wire logic [2:0]  s_tuser,   // [2:0] byte_count
    input  wire logic        s_tlast,   // last_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] digest_word
    output logic [1:0]       m_tuser,   // [1:0] word_index
    output logic             m_tlast    // digest_done
);
    import md4_pkg::*;

    // Controller states.
    localparam logic [2:0] ST_IDLE  = 3'd0;  // taking message words
    localparam logic [2:0] ST_PAD   = 3'd1;  // pushing padding and length words
    localparam logic [2:0] ST_COMP  = 3'd2;  // running the 48 steps
    localparam logic [2:0] ST_FINAL = 3'd3;  // adding working words into chaining words
    localparam logic [2:0] ST_OUT   = 3'd4;  // delivering the digest

    // Padding phases.
    localparam logic [1:0] PH_MARK  = 2'd0;  // the 0x80 word after a full last word
    localparam logic [1:0] PH_ZERO  = 2'd1;  // zeros up to word 13, then the low length in word 14
    localparam logic [1:0] PH_LENHI = 2'd2;  // high length word
    localparam logic [1:0] PH_DONE  = 2'd3;  // everything pushed

    logic [2:0]        st_reg, st_next;
    logic [1:0]        ph_reg, ph_next;
    logic              pad_reg, pad_next;
    logic [ADDR_W-1:0] fill_reg, fill_next;
    logic [63:0]       len_reg, len_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        idx_reg, idx_next;
    logic [WORD_W-1:0] chain_reg [4];
    logic [WORD_W-1:0] chain_next [4];

    logic [WORD_W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [WORD_W-1:0] a_next, b_next, c_next, d_next;

    // Block buffer: one write port fed by the intake and padding logic, one
    // registered read port used by the compression steps.
    logic [WORD_W-1:0] blk_mem [BLK_WORDS];
    logic [WORD_W-1:0] rdata_reg;
    logic              push;
    logic [WORD_W-1:0] push_data;
    logic [ADDR_W-1:0] rd_addr;

    logic              s_xfer;
    logic              m_xfer;
    logic [2:0]        cnt_sat;
    logic [CNT_W-1:0]  step_idx;
    step_ctl_t         step_ctl;
    logic [WORD_W-1:0] step_t;

    assign s_tready = (st_reg == ST_IDLE);
    assign s_xfer   = s_tvalid & s_tready;
    assign m_tvalid = (st_reg == ST_OUT);
    assign m_xfer   = m_tvalid & m_tready;
    assign m_tdata  = chain_reg[idx_reg];
    assign m_tuser  = idx_reg;
    assign m_tlast  = (idx_reg == 2'd3);

    // Byte counts above four on a last word count as four.
    assign cnt_sat  = (s_tuser > 3'd4) ? 3'd4 : s_tuser;

    // The step being finished in this cycle trails the read address by one.
    assign rd_addr        = word_order(cnt_reg);
    assign step_idx       = cnt_reg - CNT_W'(1);
    assign step_ctl.round = step_idx[5:4];
    assign step_ctl.pos   = step_idx[1:0];

    md4_step u_step (
        .a_in     (a_reg),
        .b_in     (b_reg),
        .c_in     (c_reg),
        .d_in     (d_reg),
        .msg_word (rdata_reg),
        .ctl      (step_ctl),
        .t_out    (step_t)
    );

    always_comb begin
        st_next   = st_reg;
        ph_next   = ph_reg;
        pad_next  = pad_reg;
        fill_next = fill_reg;
        len_next  = len_reg;
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        chain_next = chain_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        d_next    = d_reg;
        push      = 1'b0;
        push_data = '0;

        unique case (st_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    push = 1'b1;
                    if (!s_tlast) begin
                        push_data = s_tdata;
                        len_next  = len_reg + 64'd32;
                    end else begin
                        len_next = len_reg + {58'd0, cnt_sat, 3'd0};
                        pad_next = 1'b1;
                        st_next  = ST_PAD;
                        ph_next  = PH_ZERO;
                        case (cnt_sat)
                            3'd0: push_data = PAD_MARK;
                            3'd1: push_data = {16'h0, PAD_MARK[7:0], s_tdata[7:0]};
                            3'd2: push_data = {8'h0, PAD_MARK[7:0], s_tdata[15:0]};
                            3'd3: push_data = {PAD_MARK[7:0], s_tdata[23:0]};
                            default: begin
                                push_data = s_tdata;
                                ph_next   = PH_MARK;
                            end
                        endcase
                    end
                end
            end
            ST_PAD: begin
                unique case (ph_reg)
                    PH_MARK: begin
                        push      = 1'b1;
                        push_data = PAD_MARK;
                        ph_next   = PH_ZERO;
                    end
                    PH_ZERO: begin
                        push = 1'b1;
                        if (fill_reg == ADDR_W'(BLK_WORDS - 2)) begin
                            push_data = len_reg[31:0];
                            ph_next   = PH_LENHI;
                        end else begin
                            push_data = '0;
                        end
                    end
                    PH_LENHI: begin
                        push      = 1'b1;
                        push_data = len_reg[63:32];
                        ph_next   = PH_DONE;
                    end
                    default: begin
                        st_next = ST_OUT;
                    end
                endcase
            end
            ST_COMP: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg != '0) begin
                    a_next = d_reg;
                    d_next = c_reg;
                    c_next = b_reg;
                    b_next = step_t;
                end
                if (cnt_reg == CNT_W'(STEPS)) begin
                    st_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                if (!pad_reg) begin
                    st_next = ST_IDLE;
                end else if (ph_reg == PH_DONE) begin
                    st_next = ST_OUT;
                end else begin
                    st_next = ST_PAD;
                end
            end
            ST_OUT: begin
                if (m_xfer) begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        // Digest delivered: back to the initial state for the next message.
                        st_next       = ST_IDLE;
                        pad_next      = 1'b0;
                        ph_next       = PH_MARK;
                        fill_next     = '0;
                        len_next      = '0;
                        chain_next[0] = INIT_A;
                        chain_next[1] = INIT_B;
                        chain_next[2] = INIT_C;
                        chain_next[3] = INIT_D;
                    end
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase

        // Every push advances the fill; the sixteenth word of a block starts a
        // compression with the working words loaded from the chaining words.
        if (push) begin
            fill_next = fill_reg + ADDR_W'(1);
            if (fill_reg == ADDR_W'(BLK_WORDS - 1)) begin
                st_next  = ST_COMP;
                cnt_next = '0;
                a_next   = chain_reg[0];
                b_next   = chain_reg[1];
                c_next   = chain_reg[2];
                d_next   = chain_reg[3];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            ph_reg       <= PH_MARK;
            pad_reg      <= 1'b0;
            fill_reg     <= '0;
            len_reg      <= '0;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            chain_reg[0] <= INIT_A;
            chain_reg[1] <= INIT_B;
            chain_reg[2] <= INIT_C;
            chain_reg[3] <= INIT_D;
        end else begin
            st_reg    <= st_next;
            ph_reg    <= ph_next;
            pad_reg   <= pad_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

    // Writes happen only outside compression, so a read used by the compression
    // steps never meets a write to the same entry.
    always_ff @(posedge aclk) begin
        if (push) begin
            blk_mem[fill_reg] <= push_data;
        end
        rdata_reg <= blk_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hdl/md4_step.sv -----
// One MD4 compression step: round function, additions and rotation.
`default_nettype none

module md4_step (
    input  wire logic [31:0]         a_in,
    input  wire logic [31:0]         b_in,
    input  wire logic [31:0]         c_in,
    input  wire logic [31:0]         d_in,
    input  wire logic [31:0]         msg_word,
    input  wire md4_pkg::step_ctl_t  ctl,
    output logic [31:0]              t_out
);
    import md4_pkg::*;

    logic [WORD_W-1:0] f;
    logic [WORD_W-1:0] k;
    logic [WORD_W-1:0] sum;

    always_comb begin
        case (ctl.round)
            ROUND_1: begin
                f = (b_in & c_in) | (~b_in & d_in);
                k = '0;
            end
            ROUND_2: begin
                f = (b_in & c_in) | (b_in & d_in) | (c_in & d_in);
                k = K_ROUND2;
            end
            default: begin
                f = b_in ^ c_in ^ d_in;
                k = K_ROUND3;
            end
        endcase
        sum   = a_in + f + msg_word + k;
        t_out = rotl32(sum, rot_amount(ctl));
    end

endmodule

`default_nettype wire
